>>> rtl/stereo_multi_tap_delay_macros.svh
// assertion helpers shared by the delay block
`ifndef STEREO_MULTI_TAP_DELAY_MACROS_SVH
`define STEREO_MULTI_TAP_DELAY_MACROS_SVH

// same-cycle implication, off while reset is held
`define SMTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smtd assertion failed");

// next-cycle implication, off while reset is held
`define SMTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smtd assertion failed");

`endif

>>> rtl/smtd_pkg.sv
`default_nettype none

package smtd_pkg;

    localparam int GAIN_W       = 16;
    localparam int DELAY_W      = 12;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int FRAC_W       = 15;
    localparam int STEP_W       = 4;
    localparam int DRAIN_CYCLES = 3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP_MOD,
        ST_TAP_WR,
        ST_SAMPLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic mod_en;
        logic tap_wr;
        logic hist_wr;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/smtd_ctrl.sv
`default_nettype none
`include "stereo_multi_tap_delay_macros.svh"

module smtd_ctrl
    import smtd_pkg::*;
#(
    parameter int MAX_TAPS = 64,
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_kind,
    output logic                    o_stall,
    input  wire logic               i_cfg_valid,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    output logic                    o_cfg_ready,
    input  wire t_status            i_status,
    output t_cmd                    o_cmd,
    output logic [TAP_AW-1:0]       o_tap_addr
);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_tap, n_tap;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [COUNT_W-1:0]  r_tap_count;
    logic [COUNT_W-1:0]  w_taps;

    // tap count clamps to the table size
    assign w_taps = (32'(r_tap_count) > MAX_TAPS) ? COUNT_W'(MAX_TAPS) : r_tap_count;

    assign o_cfg_ready = 1'b1;
    assign o_tap_addr  = TAP_AW'(r_tap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_step      <= '0;
            r_tap_count <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_step  <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_step  = r_step;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_kind == KIND_TAP) begin
                        n_state = ST_TAP_MOD;
                    end else begin
                        n_state = ST_SAMPLE;
                    end
                end
            end
            ST_TAP_MOD: begin
                // quotient of the delay by the ring depth
                o_cmd.mod_en = 1'b1;
                n_state      = ST_TAP_WR;
            end
            ST_TAP_WR: begin
                o_cmd.tap_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SAMPLE: begin
                o_cmd.hist_wr = 1'b1;
                n_tap         = '0;
                if (w_taps == '0) begin
                    n_state = ST_DRAIN;
                    n_step  = STEP_W'(DRAIN_CYCLES - 1);
                end else begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_tap       = r_tap + 1'b1;
                if (r_tap == w_taps - 1'b1) begin
                    n_state = ST_DRAIN;
                    n_step  = STEP_W'(DRAIN_CYCLES - 1);
                end
            end
            ST_DRAIN: begin
                // let the last products reach the accumulators
                if (r_step == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SMTD_ASSERT_NOW(a_issue_in_range, i_clk, i_rst_n, o_cmd.issue, r_tap < w_taps)
    `SMTD_ASSERT_NOW(a_finish_free, i_clk, i_rst_n, o_cmd.finish, !i_status.out_busy)
    `SMTD_ASSERT_NEXT(a_mod_then_write, i_clk, i_rst_n, r_state == ST_TAP_MOD, o_cmd.tap_wr)

endmodule

`default_nettype wire

>>> rtl/smtd_dpath.sv
`default_nettype none
`include "stereo_multi_tap_delay_macros.svh"

module smtd_dpath
    import smtd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_TAPS      = 64,
    parameter int SAMPLE_BITS   = 16,
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    output t_status                            o_status,
    input  wire logic [TAP_AW-1:0]             i_tap_addr,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic [INDEX_W-1:0]            i_tap_index,
    input  wire logic [DELAY_W-1:0]            i_tap_delay,
    input  wire logic signed [GAIN_W-1:0]      i_gain_right,
    input  wire logic signed [GAIN_W-1:0]      i_gain_left,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_out_right,
    output logic signed [SAMPLE_BITS-1:0]      o_out_left,
    output logic                               o_clipped
);

    localparam int HAW  = $clog2(HISTORY_DEPTH);
    localparam int TE_W = HAW + 2 * GAIN_W;
    localparam int PW   = SAMPLE_BITS + GAIN_W;
    localparam int ACCW = PW + COUNT_W;

    // reciprocal of the ring depth, exact for every delay below 2^DELAY_W
    localparam int RCP_S = DELAY_W + HAW;
    localparam int RCP_M = ((1 << RCP_S) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

    localparam logic signed [ACCW:0] ROUND_BIAS = (ACCW + 1)'(1) << (FRAC_W - 1);

    // captured item
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [INDEX_W-1:0]            r_index;
    logic [DELAY_W-1:0]            r_delay;
    logic [DELAY_W-1:0]            r_quot;
    logic signed [GAIN_W-1:0]      r_gain_r_in, r_gain_l_in;

    // stores
    logic [TE_W-1:0]               mem_tap [MAX_TAPS];
    logic [SAMPLE_BITS-1:0]        mem_hist [HISTORY_DEPTH];

    // ring control
    logic [HAW-1:0]                r_wp;
    logic [HAW:0]                  r_fill;

    // mac pipeline
    logic                          r_v1, r_v2, r_v3;
    logic [TE_W-1:0]               r_tap_q;
    logic [SAMPLE_BITS-1:0]        r_x;
    logic                          r_x_ok;
    logic signed [GAIN_W-1:0]      r_g_r, r_g_l;
    logic signed [PW-1:0]          r_p_r, r_p_l;
    logic signed [ACCW-1:0]        r_acc_r, r_acc_l;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_r, r_out_l;
    logic                          r_clip;

    logic [31:0]                   w_quot_prod;
    logic [DELAY_W-1:0]            w_delay_mod;
    logic [HAW-1:0]                w_tap_delay;
    logic [HAW:0]                  w_diff;
    logic [HAW-1:0]                w_pos;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [PW-1:0]          w_p_r, w_p_l;
    logic signed [ACCW:0]          w_sum_r, w_sum_l, w_q_r, w_q_l;
    logic                          w_fit_r, w_fit_l;
    logic signed [SAMPLE_BITS-1:0] w_sat_r, w_sat_l;

    assign w_quot_prod = 32'(r_delay) * 32'(RCP_M);
    assign w_delay_mod = r_delay - DELAY_W'(32'(r_quot) * 32'(HISTORY_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample    <= i_sample_in;
            r_index     <= i_tap_index;
            r_delay     <= i_tap_delay;
            r_gain_r_in <= i_gain_right;
            r_gain_l_in <= i_gain_left;
        end
        if (i_cmd.mod_en) begin
            r_quot <= DELAY_W'(w_quot_prod >> RCP_S);
        end
    end

    // tap table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_wr && (32'(r_index) < MAX_TAPS)) begin
            mem_tap[TAP_AW'(r_index)] <= {HAW'(w_delay_mod), r_gain_r_in, r_gain_l_in};
        end
        r_tap_q <= mem_tap[i_tap_addr];
    end

    // read position: write position minus delay, wrapped on the ring
    assign w_tap_delay = r_tap_q[TE_W-1 -: HAW];
    assign w_diff      = {1'b0, r_wp} - {1'b0, w_tap_delay};
    assign w_pos       = w_diff[HAW] ? HAW'(w_diff + (HAW + 1)'(HISTORY_DEPTH))
                                     : w_diff[HAW-1:0];

    // sample history, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_wr) begin
            mem_hist[r_wp] <= r_sample;
        end
        r_x    <= mem_hist[w_pos];
        r_x_ok <= ({1'b0, w_pos} < r_fill);
        r_g_r  <= r_tap_q[2*GAIN_W-1 -: GAIN_W];
        r_g_l  <= r_tap_q[GAIN_W-1:0];
    end

    // entries not yet written since reset read as zero
    assign w_x   = r_x_ok ? $signed(r_x) : '0;
    assign w_p_r = w_x * r_g_r;
    assign w_p_l = w_x * r_g_l;

    always_ff @(posedge i_clk) begin
        r_p_r <= w_p_r;
        r_p_l <= w_p_l;
        if (i_cmd.hist_wr) begin
            r_acc_r <= '0;
            r_acc_l <= '0;
        end else if (r_v3) begin
            r_acc_r <= r_acc_r + ACCW'(r_p_r);
            r_acc_l <= r_acc_l + ACCW'(r_p_l);
        end
    end

    // round half up, drop the fraction, saturate
    assign w_sum_r = {r_acc_r[ACCW-1], r_acc_r} + ROUND_BIAS;
    assign w_sum_l = {r_acc_l[ACCW-1], r_acc_l} + ROUND_BIAS;
    assign w_q_r   = w_sum_r >>> FRAC_W;
    assign w_q_l   = w_sum_l >>> FRAC_W;
    assign w_fit_r = (&w_q_r[ACCW:SAMPLE_BITS-1]) || !(|w_q_r[ACCW:SAMPLE_BITS-1]);
    assign w_fit_l = (&w_q_l[ACCW:SAMPLE_BITS-1]) || !(|w_q_l[ACCW:SAMPLE_BITS-1]);
    assign w_sat_r = w_fit_r ? w_q_r[SAMPLE_BITS-1:0]
                   : (w_q_r[ACCW] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    assign w_sat_l = w_fit_l ? w_q_l[SAMPLE_BITS-1:0]
                   : (w_q_l[ACCW] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_r <= w_sat_r;
            r_out_l <= w_sat_l;
            r_clip  <= !w_fit_r || !w_fit_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.hist_wr && (r_fill != (HAW + 1)'(HISTORY_DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.finish) begin
                r_wp <= (r_wp == HAW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_out_right       = r_out_r;
    assign o_out_left        = r_out_l;
    assign o_clipped         = r_clip;

    `SMTD_ASSERT_NOW(a_delay_mod, i_clk, i_rst_n, i_cmd.tap_wr, 32'(w_delay_mod) < HISTORY_DEPTH)
    `SMTD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, 32'(r_fill) <= HISTORY_DEPTH)
    `SMTD_ASSERT_NOW(a_wp_bound, i_clk, i_rst_n, 1'b1, 32'(r_wp) < HISTORY_DEPTH)

endmodule

`default_nettype wire

>>> rtl/stereo_multi_tap_delay.sv
// mono-in, stereo-out multi-tap delay (early reflections)
// input channel: i_valid / o_stall, transfer when i_valid is high and o_stall low.
//   i_kind selects a sample item or a tap table write (index, delay, two gains).
// output channel: o_valid / i_stall, one stereo result per sample item, none
//   for a tap write; a transfer happens when o_valid is high and i_stall low.
// config: i_cfg_valid / o_cfg_ready write the tap count; ready is always high.
// a tap write stalls the input after its transfer: the controller first forms
//   the delay's quotient by the ring depth with a reciprocal multiply, then writes.
// a sample item writes its history word, issues each of the n taps, n being the
//   clamped tap count, drains the pipeline and loads its result; only then is the
//   next item taken. the taps run through the single shared multiply-accumulate
//   pipeline, which reads one tap entry and one history word per cycle.
// the result sits in an output register; while the receiver stalls, a new item
//   is still taken and worked on, and only its final load waits for the slot.
// reset (synchronous, active low) clears the write position, the tap count and
//   the history fill count; history words not yet written read as zero, so no
//   clearing pass is needed. tap entries are undefined until written.
`default_nettype none

module stereo_multi_tap_delay
    import smtd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_TAPS      = 64,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic [INDEX_W-1:0]            i_tap_index,
    input  wire logic [DELAY_W-1:0]            i_tap_delay,
    input  wire logic signed [GAIN_W-1:0]      i_gain_right,
    input  wire logic signed [GAIN_W-1:0]      i_gain_left,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_out_right,
    output logic signed [SAMPLE_BITS-1:0]      o_out_left,
    output logic                               o_clipped,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [COUNT_W-1:0]            i_cfg_data
);

    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [TAP_AW-1:0] w_tap_addr;

    smtd_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_tap_addr  (w_tap_addr)
    );

    smtd_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_TAPS      (MAX_TAPS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_tap_addr   (w_tap_addr),
        .i_sample_in  (i_sample_in),
        .i_tap_index  (i_tap_index),
        .i_tap_delay  (i_tap_delay),
        .i_gain_right (i_gain_right),
        .i_gain_left  (i_gain_left),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_right  (o_out_right),
        .o_out_left   (o_out_left),
        .o_clipped    (o_clipped)
    );

endmodule

`default_nettype wire

>>> dv/stereo_multi_tap_delay_tb.sv
`timescale 1ns / 1ps

module stereo_multi_tap_delay_tb;
    import smtd_pkg::*;

    localparam int     SAMPLE_BITS    = 16;
    localparam int     HIST_DEPTH     = 4096;
    localparam int     TAP_SLOTS      = 64;
    localparam int     POS_W          = 12;
    localparam int     RANDOM_ITEMS   = 700;
    localparam int     TOTAL_ITEMS    = 1000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam longint SAT_HI         = 32767;
    localparam longint SAT_LO         = -32768;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] right;
        logic signed [SAMPLE_BITS-1:0] left;
        logic                          clipped;
    } t_stereo_mix;

    class tap_sum_scoreboard;
        logic signed [SAMPLE_BITS-1:0] history [HIST_DEPTH];
        logic [POS_W-1:0]              head;
        logic [DELAY_W-1:0]            tap_delay [TAP_SLOTS];
        logic signed [GAIN_W-1:0]      tap_gain_r [TAP_SLOTS];
        logic signed [GAIN_W-1:0]      tap_gain_l [TAP_SLOTS];
        logic [COUNT_W-1:0]            tap_count;
        t_stereo_mix                   expected_mixes [$];
        int                            errors;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (tap_delay[i]) begin
                tap_delay[i]  = '0;
                tap_gain_r[i] = '0;
                tap_gain_l[i] = '0;
            end
            head      = '0;
            tap_count = '0;
            errors    = 0;
        endfunction

        // round half up, drop the fraction bits, clamp to the sample range
        function logic signed [SAMPLE_BITS-1:0] round_sat(longint acc, inout bit clip);
            longint v;
            v = (acc + 64'sd16384) >>> FRAC_W;
            if (v > SAT_HI) begin
                clip = 1'b1;
                return SAT_HI[SAMPLE_BITS-1:0];
            end
            if (v < SAT_LO) begin
                clip = 1'b1;
                return SAT_LO[SAMPLE_BITS-1:0];
            end
            return v[SAMPLE_BITS-1:0];
        endfunction

        function void note_transfer(logic kind, logic signed [SAMPLE_BITS-1:0] sample,
                                    logic [INDEX_W-1:0] idx, logic [DELAY_W-1:0] dly,
                                    logic signed [GAIN_W-1:0] gr,
                                    logic signed [GAIN_W-1:0] gl);
            longint           acc_r;
            longint           acc_l;
            int               n;
            logic [POS_W-1:0] pos;
            bit               clip;
            t_stereo_mix      mix;
            if (kind == KIND_TAP) begin
                tap_delay[idx]  = dly;
                tap_gain_r[idx] = gr;
                tap_gain_l[idx] = gl;
                return;
            end
            history[head] = sample;
            n     = (tap_count > TAP_SLOTS) ? TAP_SLOTS : tap_count;
            acc_r = 0;
            acc_l = 0;
            clip  = 1'b0;
            for (int t = 0; t < n; t++) begin
                // ring index wraps naturally at the pointer width
                pos   = head - tap_delay[t];
                acc_r += longint'(history[pos]) * longint'(tap_gain_r[t]);
                acc_l += longint'(history[pos]) * longint'(tap_gain_l[t]);
            end
            mix.right   = round_sat(acc_r, clip);
            mix.left    = round_sat(acc_l, clip);
            mix.clipped = clip;
            expected_mixes.push_back(mix);
            head++;
        endfunction

        function void check_mix(logic signed [SAMPLE_BITS-1:0] right,
                                logic signed [SAMPLE_BITS-1:0] left, logic clipped);
            t_stereo_mix want;
            if (expected_mixes.size() == 0) begin
                $error("output transfer with no result pending: right %0d left %0d",
                       right, left);
                errors++;
                return;
            end
            want = expected_mixes.pop_front();
            if (right !== want.right) begin
                $error("out_right: expected %0d, actual %0d", want.right, right);
                errors++;
            end
            if (left !== want.left) begin
                $error("out_left: expected %0d, actual %0d", want.left, left);
                errors++;
            end
            if (clipped !== want.clipped) begin
                $error("clipped: expected %0d, actual %0d", want.clipped, clipped);
                errors++;
            end
        endfunction

        function void close();
            if (expected_mixes.size() != 0) begin
                $error("%0d results never arrived", expected_mixes.size());
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          i_kind       = KIND_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] i_sample_in  = '0;
    logic [INDEX_W-1:0]            i_tap_index  = '0;
    logic [DELAY_W-1:0]            i_tap_delay  = '0;
    logic signed [GAIN_W-1:0]      i_gain_right = '0;
    logic signed [GAIN_W-1:0]      i_gain_left  = '0;
    logic                          i_stall      = 1'b0;
    logic                          i_cfg_valid  = 1'b0;
    logic [COUNT_W-1:0]            i_cfg_data   = '0;
    logic                          o_stall;
    logic                          o_valid;
    logic signed [SAMPLE_BITS-1:0] o_out_right;
    logic signed [SAMPLE_BITS-1:0] o_out_left;
    logic                          o_clipped;
    logic                          o_cfg_ready;

    tap_sum_scoreboard sb = new();
    bit                tap_written [TAP_SLOTS];
    bit                no_idle      = 1'b0;
    int                items_sent   = 0;
    int                stall_left   = 0;
    int                quiet_cycles = 0;

    stereo_multi_tap_delay #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .MAX_TAPS     (TAP_SLOTS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_sample_in (i_sample_in),
        .i_tap_index (i_tap_index),
        .i_tap_delay (i_tap_delay),
        .i_gain_right(i_gain_right),
        .i_gain_left (i_gain_left),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_right (o_out_right),
        .o_out_left  (o_out_left),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver back-pressure in short bursts
    always @(posedge i_clk) begin
        if (no_idle || stall_left == 0) begin
            i_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
        end else begin
            i_stall <= 1'b1;
            stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_mix(o_out_right, o_out_left, o_clipped);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [GAIN_W-1:0] pick_q15();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return GAIN_W'(int'($urandom_range(0, 7)) - 4);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 3))
            0: return DELAY_W'($urandom_range(0, 15));
            1: return DELAY_W'(32'hFFF - $urandom_range(0, 3));
            default: return DELAY_W'($urandom);
        endcase
    endfunction

    // taps 0 .. n-1 all written, so any count up to n reads only loaded entries
    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < TAP_SLOTS && tap_written[n])
            n++;
        return n;
    endfunction

    task automatic send_item(logic kind, logic signed [SAMPLE_BITS-1:0] sample,
                             logic [INDEX_W-1:0] idx, logic [DELAY_W-1:0] dly,
                             logic signed [GAIN_W-1:0] gr, logic signed [GAIN_W-1:0] gl);
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_sample_in  <= sample;
        i_tap_index  <= idx;
        i_tap_delay  <= dly;
        i_gain_right <= gr;
        i_gain_left  <= gl;
        do @(posedge i_clk); while (o_stall);
        sb.note_transfer(kind, sample, idx, dly, gr, gl);
        items_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // tap fields ride along with random content and must be ignored
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample);
        send_item(KIND_SAMPLE, sample, INDEX_W'($urandom), DELAY_W'($urandom),
                  GAIN_W'($urandom), GAIN_W'($urandom));
    endtask

    task automatic send_tap(logic [INDEX_W-1:0] idx, logic [DELAY_W-1:0] dly,
                            logic signed [GAIN_W-1:0] gr, logic signed [GAIN_W-1:0] gl);
        tap_written[idx] = 1'b1;
        send_item(KIND_TAP, SAMPLE_BITS'($urandom), idx, dly, gr, gl);
    endtask

    // only written once all results are in and a tap write has had time to land
    task automatic set_tap_count(logic [COUNT_W-1:0] count);
        i_valid <= 1'b0;
        while (sb.expected_mixes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.tap_count = count;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                 prefix;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] idx;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tap count is zero out of reset, so the first mix is silent
        send_sample(16'sh7FFF);
        send_tap(0, 0, 16'sh4000, -16'sh4000);
        send_tap(1, 1, 16'sh8000, 16'sh8000);
        send_tap(2, 12'hFFF, 16'sh7FFF, 16'sh7FFF);
        send_tap(INDEX_W'(TAP_SLOTS - 1), 12'hFFF, -1, 1);
        set_tap_count(1);
        // half-gain taps land exactly on the rounding midpoint
        send_sample(1);
        send_sample(-1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_tap(0, 0, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(0);
        set_tap_count(3);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);

        for (int ph = 0; items_sent < RANDOM_ITEMS; ph++) begin
            prefix = written_prefix();
            case (ph % 5)
                0: count = 0;
                1: count = (prefix == TAP_SLOTS) ? 7'd127 : COUNT_W'(prefix);
                2: count = COUNT_W'(prefix);
                default: count = COUNT_W'($urandom_range(0,
                                           (prefix == TAP_SLOTS) ? 127 : prefix));
            endcase
            set_tap_count(count);
            repeat (120) begin
                if ($urandom_range(0, 3) == 0) begin
                    prefix = written_prefix();
                    if (prefix < TAP_SLOTS && $urandom_range(0, 3) != 0)
                        idx = INDEX_W'(prefix);
                    else
                        idx = INDEX_W'($urandom_range(0, TAP_SLOTS - 1));
                    send_tap(idx, pick_delay(), pick_q15(), pick_q15());
                end else begin
                    send_sample(pick_q15());
                end
            end
        end

        // last stretch runs flat out
        no_idle <= 1'b1;
        send_tap(0, 12'hFFF, pick_q15(), pick_q15());
        send_tap(1, 12'd2048, pick_q15(), pick_q15());
        send_tap(2, 1, pick_q15(), pick_q15());
        send_tap(3, 0, pick_q15(), pick_q15());
        set_tap_count(4);
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 63) == 0)
                send_tap(INDEX_W'($urandom_range(0, 3)), pick_delay(), pick_q15(),
                         pick_q15());
            else
                send_sample(pick_q15());
        end

        i_valid <= 1'b0;
        while (sb.expected_mixes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.close();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/smtd_pkg.sv
rtl/smtd_ctrl.sv
rtl/smtd_dpath.sv
rtl/stereo_multi_tap_delay.sv
dv/stereo_multi_tap_delay_tb.sv
